[hdl/mah_pkg.sv]
// mah_pkg: shared constants, types and the hex digit table for the MAC address hash.
// No dependencies; mah_word_mix and mac_address_hash_top import it.
package mah_pkg;

    localparam int unsigned NUM_STAGES = 8;

    localparam logic [31:0] MH_MUL   = 32'h5bd1e995;
    localparam logic [31:0] MH_SEED  = 32'hc70f6907;
    localparam logic [31:0] TEXT_LEN = 32'd17;
    localparam int unsigned MH_SHIFT  = 24;
    localparam int unsigned FIN_SHIFT_A = 13;
    localparam int unsigned FIN_SHIFT_B = 15;

    localparam logic [7:0] CHAR_COLON = 8'h3a;

    // seed ^ len, times the multiplier, folded at elaboration
    localparam logic [63:0] ACC_PROD = 64'(MH_SEED ^ TEXT_LEN) * 64'(MH_MUL);
    localparam logic [31:0] ACC_INIT = ACC_PROD[31:0];

    localparam logic [7:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef struct packed {
        logic en_a;
        logic en_b;
    } t_mix_ctl;

endpackage

[hdl/mah_if.sv]
// mah_mac_if / mah_hash_if: valid/ready word channels for address in and hash out.
// No dependencies.
interface mah_mac_if;
    logic        valid;
    logic        ready;
    logic [47:0] mac_address;

    modport source (output valid, output mac_address, input ready);
    modport sink   (input valid, input mac_address, output ready);
endinterface

interface mah_hash_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

[hdl/mah_word_mix.sv]
// mah_word_mix: two-stage word mix k = ((w*M) ^ ((w*M) >> 24)) * M.
// Depends on mah_pkg.
module mah_word_mix
    import mah_pkg::*;
(
    input  logic        i_clk,
    input  t_mix_ctl    i_ctl,
    input  logic [31:0] i_word,
    output logic [31:0] o_key
);

    logic [31:0] r_m;
    logic [31:0] r_k;
    logic [31:0] n_m;
    logic [31:0] n_k;

    always_comb begin
        n_m = i_word * MH_MUL;
        n_k = (r_m ^ (r_m >> MH_SHIFT)) * MH_MUL;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_a) begin
            r_m <= n_m;
        end
        if (i_ctl.en_b) begin
            r_k <= n_k;
        end
    end

    assign o_key = r_k;

endmodule

[hdl/mac_address_hash_top.sv]
// mac_address_hash_top: MurmurHash2 of the colon-separated lowercase hex text of a MAC address.
// Depends on mah_pkg, mah_if (mah_mac_if, mah_hash_if) and mah_word_mix.
//
//   channel   dir  payload               width
//   i_mac     in   mac_address           48
//   o_hash    out  hash_value            32
//
// Eight register stages: four 32x32 multiplies in stages 0 and 1, one in each of stages 2 to 6,
// and the final xor-shift in stage 7. o_hash.valid is the valid bit of stage 7.
// Takes one word per cycle while o_hash.ready stays high.
// Each stage holds when it is full and the stage after it cannot take its word;
// empty stages fill behind a stall, so i_mac.ready drops only once all eight are full.
// Synchronous active-low reset clears the valid bits only.
module mac_address_hash_top
    import mah_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    mah_mac_if.sink         i_mac,
    mah_hash_if.source      o_hash
);

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] en;

    logic [7:0]  oct [6];
    logic [31:0] word [4];
    logic [31:0] key [4];
    t_mix_ctl    mix_ctl;

    logic [3:0]  r_tail [5];
    logic [31:0] r_k1_s3;
    logic [31:0] r_k2_s3;
    logic [31:0] r_k3_s3;
    logic [31:0] r_k2_s4;
    logic [31:0] r_k3_s4;
    logic [31:0] r_k3_s5;
    logic [31:0] r_p3;
    logic [31:0] r_p4;
    logic [31:0] r_p5;
    logic [31:0] r_p6;
    logic [31:0] r_p7;
    logic [31:0] r_hash;

    logic [31:0] n_p3;
    logic [31:0] n_p4;
    logic [31:0] n_p5;
    logic [31:0] n_p6;
    logic [31:0] n_p7;
    logic [31:0] n_hash;

    // stage enables, back to front
    always_comb begin
        en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || o_hash.ready;
        for (int s = NUM_STAGES - 2; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end

    assign i_mac.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_mac.valid;
            end
            for (int s = 1; s < NUM_STAGES; s++) begin
                if (en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // address text, little-endian words
    always_comb begin
        for (int o = 0; o < 6; o++) begin
            oct[o] = i_mac.mac_address[47 - 8*o -: 8];
        end
        word[0] = {HEX_DIGITS[oct[1][7:4]], CHAR_COLON,
                   HEX_DIGITS[oct[0][3:0]], HEX_DIGITS[oct[0][7:4]]};
        word[1] = {HEX_DIGITS[oct[2][3:0]], HEX_DIGITS[oct[2][7:4]],
                   CHAR_COLON, HEX_DIGITS[oct[1][3:0]]};
        word[2] = {CHAR_COLON, HEX_DIGITS[oct[3][3:0]],
                   HEX_DIGITS[oct[3][7:4]], CHAR_COLON};
        word[3] = {HEX_DIGITS[oct[5][7:4]], CHAR_COLON,
                   HEX_DIGITS[oct[4][3:0]], HEX_DIGITS[oct[4][7:4]]};
    end

    assign mix_ctl.en_a = en[0];
    assign mix_ctl.en_b = en[1];

    for (genvar g = 0; g < 4; g++) begin : g_mix
        mah_word_mix u_mix (
            .i_clk  (i_clk),
            .i_ctl  (mix_ctl),
            .i_word (word[g]),
            .o_key  (key[g])
        );
    end

    always_comb begin
        n_p3   = (ACC_INIT ^ key[0]) * MH_MUL;
        n_p4   = (r_p3 ^ r_k1_s3) * MH_MUL;
        n_p5   = (r_p4 ^ r_k2_s4) * MH_MUL;
        n_p6   = (r_p5 ^ r_k3_s5 ^ {24'd0, HEX_DIGITS[r_tail[4]]}) * MH_MUL;
        n_p7   = (r_p6 ^ (r_p6 >> FIN_SHIFT_A)) * MH_MUL;
        n_hash = r_p7 ^ (r_p7 >> FIN_SHIFT_B);
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_tail[0] <= oct[5][3:0];
        end
        if (en[1]) begin
            r_tail[1] <= r_tail[0];
        end
        if (en[2]) begin
            r_tail[2] <= r_tail[1];
            r_p3      <= n_p3;
            r_k1_s3   <= key[1];
            r_k2_s3   <= key[2];
            r_k3_s3   <= key[3];
        end
        if (en[3]) begin
            r_tail[3] <= r_tail[2];
            r_p4      <= n_p4;
            r_k2_s4   <= r_k2_s3;
            r_k3_s4   <= r_k3_s3;
        end
        if (en[4]) begin
            r_tail[4] <= r_tail[3];
            r_p5      <= n_p5;
            r_k3_s5   <= r_k3_s4;
        end
        if (en[5]) begin
            r_p6 <= n_p6;
        end
        if (en[6]) begin
            r_p7 <= n_p7;
        end
        if (en[7]) begin
            r_hash <= n_hash;
        end
    end

    assign o_hash.valid      = r_vld[NUM_STAGES-1];
    assign o_hash.hash_value = r_hash;

    a_accept_fills_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_mac.valid && i_mac.ready) |=> r_vld[0])
        else $error("accepted word did not enter the first stage");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !o_hash.ready) |-> !i_mac.ready)
        else $error("input taken while pipeline full and stalled");

    a_mid_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[4] && !en[4]) |=> r_vld[4])
        else $error("stalled stage lost its word");

endmodule
